[sv/tdq_pkg.sv]
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types and constants for the sorted deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

    localparam int CAPACITY   = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TIME_W     = 32;
    localparam int HANDLE_W   = 16;
    localparam int DELAY_W    = 24;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_SET_ONCE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_PER  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RUN      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK     = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE     = 2'd3;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_EXEC,
        DP_SCAN,
        DP_INSERT,
        DP_CLR_STEP,
        DP_CLR_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic ins_go;     // an insert is pending after exec
        logic clr_go;     // a clear walk is pending after exec
        logic scan_more;  // insert position not found yet
        logic clr_end;    // clear walk reached the tail
    } sts_t;

    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
        logic [DELAY_W-1:0]  period;
    } slot_t;

endpackage

`default_nettype wire

[sv/tdq_ctrl.sv]
// ----------------------------------------------------------------------------
// tdq_ctrl
// Sequencer: handshakes on both channels and steps the datapath per request.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output tdq_pkg::cmd_t      cmd,
    input  wire tdq_pkg::sts_t sts
);
    import tdq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ROUTE,
        ST_SCAN,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = DP_NOP;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.op     = DP_EXEC;
                state_next = ST_ROUTE;
            end
            ST_ROUTE:
            begin
                if (sts.ins_go)
                    state_next = ST_SCAN;
                else if (sts.clr_go)
                    state_next = ST_CLEAR;
                else
                    state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (sts.scan_more)
                    cmd.op = DP_SCAN;
                else
                begin
                    cmd.op     = DP_INSERT;
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                if (sts.clr_end)
                begin
                    cmd.op     = DP_CLR_DONE;
                    state_next = ST_DONE;
                end
                else
                    cmd.op = DP_CLR_STEP;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[sv/tdq_dp.sv]
// ----------------------------------------------------------------------------
// tdq_dp
// Datapath: sorted slot file, time and handle counters, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_dp
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tdq_pkg::cmd_t                   cmd,
    output tdq_pkg::sts_t                        sts,
    input  wire logic [tdq_pkg::REQ_W-1:0]       req_type,
    input  wire logic [tdq_pkg::DELAY_W-1:0]     delay_ms,
    input  wire logic [tdq_pkg::HANDLE_W-1:0]    target_handle,
    output logic      [tdq_pkg::STATUS_W-1:0]    status,
    output logic      [tdq_pkg::HANDLE_W-1:0]    result_handle,
    output logic                                 fired_periodic
);
    import tdq_pkg::*;

    // slot file: valid entries sit in 0 .. count-1, head at 0
    slot_t slot_reg [CAPACITY];
    slot_t up_src   [CAPACITY];
    slot_t dn_src   [CAPACITY];

    logic [TIME_W-1:0]   now_reg;
    logic [HANDLE_W-1:0] next_handle_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                found_reg;
    logic                ins_go_reg;
    logic                clr_go_reg;

    logic [REQ_W-1:0]    req_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic [HANDLE_W-1:0] target_reg;

    logic [TIME_W-1:0]   ins_deadline_reg;
    logic [DELAY_W-1:0]  ins_key_reg;
    logic [HANDLE_W-1:0] ins_handle_reg;
    logic [DELAY_W-1:0]  ins_period_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [HANDLE_W-1:0] res_handle_reg;
    logic                res_periodic_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic                out_periodic_reg;

    slot_t               rd_slot;
    slot_t               head;
    slot_t               new_slot;
    logic signed [TIME_W-1:0] rd_left;
    logic signed [TIME_W-1:0] head_left;
    logic signed [TIME_W-1:0] key_ext;
    logic                full;
    logic                fire;
    logic                hit;
    logic                ins_en;
    logic                rem_en;
    logic [CNT_W-1:0]    rem_pos;

    assign rd_slot   = slot_reg[idx_reg[IDX_W-1:0]];
    assign head      = slot_reg[0];
    assign new_slot  = '{deadline: ins_deadline_reg, handle: ins_handle_reg,
                         period: ins_period_reg};
    assign rd_left   = rd_slot.deadline - now_reg;
    assign head_left = head.deadline - now_reg;
    assign key_ext   = {{(TIME_W-DELAY_W){1'b0}}, ins_key_reg};

    assign full = (count_reg == CNT_W'(CAPACITY));
    assign fire = (count_reg != '0) && (head_left <= 0);
    assign hit  = (rd_slot.handle == target_reg);

    assign sts.ins_go    = ins_go_reg;
    assign sts.clr_go    = clr_go_reg;
    assign sts.scan_more = (idx_reg < count_reg) && (rd_left <= key_ext);
    assign sts.clr_end   = (idx_reg >= count_reg);

    assign ins_en  = (cmd.op == DP_INSERT);
    assign rem_en  = ((cmd.op == DP_EXEC) && (req_reg == REQ_RUN) && fire)
                  || ((cmd.op == DP_CLR_STEP) && hit);
    assign rem_pos = (cmd.op == DP_CLR_STEP) ? idx_reg : '0;

    assign status         = out_status_reg;
    assign result_handle  = out_handle_reg;
    assign fired_periodic = out_periodic_reg;

    // insert shifts the tail up by one, remove shifts it down by one
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_slot
        localparam logic [CNT_W-1:0] POS  = CNT_W'(g);
        localparam logic [CNT_W-1:0] POS1 = CNT_W'(g + 1);

        if (g == 0)
        begin : g_first
            assign up_src[g] = slot_reg[g];
        end
        else
        begin : g_up
            assign up_src[g] = slot_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign dn_src[g] = slot_reg[g];
        end
        else
        begin : g_dn
            assign dn_src[g] = slot_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (ins_en)
            begin
                if (POS == idx_reg)
                    slot_reg[g] <= new_slot;
                else if ((POS > idx_reg) && (POS <= count_reg))
                    slot_reg[g] <= up_src[g];
            end
            else if (rem_en)
            begin
                if ((POS >= rem_pos) && (POS1 < count_reg))
                    slot_reg[g] <= dn_src[g];
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg         <= '0;
            next_handle_reg <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            ins_go_reg      <= 1'b0;
            clr_go_reg      <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                DP_LOAD:
                begin
                    ins_go_reg <= 1'b0;
                    clr_go_reg <= 1'b0;
                end
                DP_EXEC:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    case (req_reg) inside
                        REQ_SET_ONCE, REQ_SET_PER:
                        begin
                            if (!full)
                            begin
                                next_handle_reg <= next_handle_reg + 1'b1;
                                ins_go_reg      <= 1'b1;
                            end
                        end
                        REQ_CLEAR:
                            clr_go_reg <= 1'b1;
                        REQ_RUN:
                        begin
                            if (fire)
                            begin
                                count_reg  <= count_reg - 1'b1;
                                ins_go_reg <= (head.period != '0);
                            end
                        end
                        REQ_TICK:
                            now_reg <= now_reg + 1'b1;
                        default:
                        begin
                        end
                    endcase
                end
                DP_SCAN:
                    idx_reg <= idx_reg + 1'b1;
                DP_INSERT:
                begin
                    count_reg  <= count_reg + 1'b1;
                    ins_go_reg <= 1'b0;
                end
                DP_CLR_STEP:
                begin
                    if (hit)
                    begin
                        count_reg <= count_reg - 1'b1;
                        found_reg <= 1'b1;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                DP_CLR_DONE:
                    clr_go_reg <= 1'b0;
                default:
                begin
                end
            endcase
        end
    end

    // request, insert and result payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                req_reg    <= req_type;
                delay_reg  <= delay_ms;
                target_reg <= target_handle;
            end
            DP_EXEC:
            begin
                res_status_reg   <= STAT_OK;
                res_handle_reg   <= '0;
                res_periodic_reg <= 1'b0;
                case (req_reg) inside
                    REQ_SET_ONCE, REQ_SET_PER:
                    begin
                        if (full)
                            res_status_reg <= STAT_FULL;
                        else
                        begin
                            res_handle_reg   <= next_handle_reg;
                            ins_deadline_reg <= now_reg + TIME_W'(delay_reg);
                            ins_key_reg      <= delay_reg;
                            ins_handle_reg   <= next_handle_reg;
                            ins_period_reg   <= (req_reg == REQ_SET_PER) ? delay_reg : '0;
                        end
                    end
                    REQ_CLEAR:
                        res_handle_reg <= target_reg;
                    REQ_RUN:
                    begin
                        if (!fire)
                            res_status_reg <= STAT_NONE;
                        else
                        begin
                            res_handle_reg   <= head.handle;
                            res_periodic_reg <= (head.period != '0);
                            ins_deadline_reg <= now_reg + TIME_W'(head.period);
                            ins_key_reg      <= head.period;
                            ins_handle_reg   <= head.handle;
                            ins_period_reg   <= head.period;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            DP_CLR_DONE:
                res_status_reg <= found_reg ? STAT_OK : STAT_NOTFOUND;
            default:
            begin
            end
        endcase

        if (cmd.out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_handle_reg   <= res_handle_reg;
            out_periodic_reg <= res_periodic_reg;
        end
    end

endmodule

`default_nettype wire

[sv/sorted_deadline_timer_queue.sv]
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Deadline-sorted timer queue with a millisecond counter, one result per
// request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per transfer:
//   set one-shot, set periodic, clear by handle, run next, or tick.
//   Output channel (out_valid / out_stall) returns exactly one result
//   (status, result_handle, fired_periodic) per request, in order.
//   Tick, set on a full queue, run with nothing due and a one-shot fire
//   pass through exec, route and done only. A set or a periodic
//   reschedule walks the sorted slots one compare per cycle and then
//   inserts. A clear steps once per occupied slot plus a closing step. One
//   request is in flight at a time.
//   A finished result sits in the output register; the next request is
//   taken while it waits, and the sequencer holds its next result until
//   the receiver lifts out_stall.
//   Reset (rst_n, async, low) empties the queue, zeroes the ms counter and
//   the handle counter, and drops any pending result. Slot contents have
//   no reset; only the fill count marks them valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_deadline_timer_queue
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [tdq_pkg::REQ_W-1:0]       req_type,
    input  wire logic [tdq_pkg::DELAY_W-1:0]     delay_ms,
    input  wire logic [tdq_pkg::HANDLE_W-1:0]    target_handle,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [tdq_pkg::STATUS_W-1:0]    status,
    output logic      [tdq_pkg::HANDLE_W-1:0]    result_handle,
    output logic                                 fired_periodic
);
    import tdq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: owns both handshakes
    tdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: slot file, counters and result payload
    tdq_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .delay_ms       (delay_ms),
        .target_handle  (target_handle),
        .status         (status),
        .result_handle  (result_handle),
        .fired_periodic (fired_periodic)
    );

endmodule

`default_nettype wire

[tb/sorted_deadline_timer_queue_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_tb
// Self-checking bench for the deadline-sorted timer queue. A behavioral copy
// of the queue predicts every reply at the moment a request transfer is
// taken. Phases: a directed table, a fill-to-full pass, then weighted random
// traffic with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module sorted_deadline_timer_queue_tb;

    import tdq_pkg::*;

    // unused request codes; the block must answer them with a plain OK
    localparam logic [REQ_W-1:0] REQ_RESV_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RESV_HI = 3'd7;

    localparam int RANDOM_ITEMS  = 1650;
    localparam int SETTLE_CYCLES = 50;
    // ~1.7k requests with gaps and stalls, x10 margin
    localparam int CYCLE_LIMIT   = 500_000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic                periodic;
    } reply_t;

    // one line of the directed table; fixed = reply typed in by hand
    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [DELAY_W-1:0]  dly;
        logic [HANDLE_W-1:0] tgt;
        logic                fixed;
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic                periodic;
    } step_row_t;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type      = REQ_TICK;
    logic [DELAY_W-1:0]  delay_ms      = '0;
    logic [HANDLE_W-1:0] target_handle = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] result_handle;
    logic                fired_periodic;

    sorted_deadline_timer_queue uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .delay_ms       (delay_ms),
        .target_handle  (target_handle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .result_handle  (result_handle),
        .fired_periodic (fired_periodic)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Timer queue shadow: slots 0..timer_count-1 in deadline order.
    // ------------------------------------------------------------------
    slot_t               timers [CAPACITY];
    int                  timer_count = 0;
    logic [TIME_W-1:0]   ms_now      = '0;
    logic [HANDLE_W-1:0] handle_next = '0;

    reply_t expected_replies [$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    bit     idle_on        = 1'b1;   // random gaps/stalls enabled
    int     hold_left      = 0;      // stall cycles left for the waiting reply
    reply_t oldest_reply;

    // Signed distance to now; order and due test both use it, so the
    // counter can wrap without breaking the sort.
    function automatic logic signed [TIME_W-1:0] time_left(input logic [TIME_W-1:0] dl);
        return $signed(dl - ms_now);
    endfunction

    // Equal deadlines go behind existing ones (FIFO).
    task automatic enqueue_timer(input logic [TIME_W-1:0] dl, input logic [HANDLE_W-1:0] hd,
                                 input logic [DELAY_W-1:0] per);
        int pos;
        pos = 0;
        while (pos < timer_count && time_left(timers[pos].deadline) <= time_left(dl))
            pos++;
        for (int i = timer_count; i > pos; i--)
            timers[i] = timers[i-1];
        timers[pos].deadline = dl;
        timers[pos].handle   = hd;
        timers[pos].period   = per;
        timer_count++;
    endtask

    task automatic drop_timer(input int pos);
        for (int i = pos; i + 1 < timer_count; i++)
            timers[i] = timers[i+1];
        timer_count--;
    endtask

    // Advances the shadow by one request and returns the reply it owes.
    task automatic apply_timer_request(input logic [REQ_W-1:0] kind,
                                       input logic [DELAY_W-1:0] dly,
                                       input logic [HANDLE_W-1:0] tgt,
                                       output reply_t r);
        int    i;
        bit    hit;
        slot_t head;
        r        = '0;
        r.status = STAT_OK;
        case (kind) inside
            REQ_SET_ONCE, REQ_SET_PER:
            begin
                if (timer_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    r.handle = handle_next;
                    handle_next++;
                    // a periodic set with zero delay degrades to one-shot
                    enqueue_timer(ms_now + dly, r.handle, (kind == REQ_SET_PER) ? dly : '0);
                end
            end
            REQ_CLEAR:
            begin
                r.handle = tgt;
                hit = 1'b0;
                i = 0;
                // every copy of a reused handle goes
                while (i < timer_count)
                begin
                    if (timers[i].handle == tgt)
                    begin
                        drop_timer(i);
                        hit = 1'b1;
                    end
                    else
                        i++;
                end
                r.status = hit ? STAT_OK : STAT_NOTFOUND;
            end
            REQ_RUN:
            begin
                if (timer_count == 0 || time_left(timers[0].deadline) > 0)
                    r.status = STAT_NONE;
                else
                begin
                    head = timers[0];
                    drop_timer(0);
                    r.handle = head.handle;
                    if (head.period != '0)
                    begin
                        enqueue_timer(ms_now + head.period, head.handle, head.period);
                        r.periodic = 1'b1;
                    end
                end
            end
            REQ_TICK:
                ms_now++;
            default:
                ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side. Valid stays up across back-to-back transfers; it only
    // drops when a gap is drawn.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [DELAY_W-1:0] dly,
                                input logic [HANDLE_W-1:0] tgt, input bit fixed,
                                input logic [STATUS_W-1:0] st, input logic [HANDLE_W-1:0] hd,
                                input logic pe);
        int     gap;
        reply_t predicted;
        reply_t typed;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= kind;
        delay_ms      <= dly;
        target_handle <= tgt;
        do @(posedge clk); while (in_stall);
        // transfer taken at this edge
        apply_timer_request(kind, dly, tgt, predicted);
        typed.status   = st;
        typed.handle   = hd;
        typed.periodic = pe;
        expected_replies.push_back(fixed ? typed : predicted);
    endtask

    function automatic step_row_t plan_row(input logic [REQ_W-1:0] kind,
                                           input logic [DELAY_W-1:0] dly,
                                           input logic [HANDLE_W-1:0] tgt, input logic fixed,
                                           input logic [STATUS_W-1:0] st,
                                           input logic [HANDLE_W-1:0] hd, input logic pe);
        step_row_t r;
        r.kind = kind; r.dly = dly; r.tgt = tgt; r.fixed = fixed;
        r.status = st; r.handle = hd; r.periodic = pe;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reply side: compare each transfer with the oldest prediction, then
    // draw how long to hold off the next reply.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: reply with nothing pending: status %0d handle %0d periodic %0d",
                             $time, status, result_handle, fired_periodic);
                    mismatch_count++;
                end
                else
                begin
                    oldest_reply = expected_replies[0];
                    expected_replies.delete(0);
                    if (status !== oldest_reply.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, oldest_reply.status, status);
                        mismatch_count++;
                    end
                    if (result_handle !== oldest_reply.handle)
                    begin
                        $display("%0t: result_handle expected %0d, got %0d",
                                 $time, oldest_reply.handle, result_handle);
                        mismatch_count++;
                    end
                    if (fired_periodic !== oldest_reply.periodic)
                    begin
                        $display("%0t: fired_periodic expected %0d, got %0d",
                                 $time, oldest_reply.periodic, fired_periodic);
                        mismatch_count++;
                    end
                end
                hold_left = idle_on ? $urandom_range(0, 3) : 0;
                out_stall <= (hold_left != 0);
            end
            else if (out_valid && hold_left != 0)
            begin
                hold_left--;
                out_stall <= (hold_left != 0);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_deadline_timer_queue test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        step_row_t           plan [$];
        step_row_t           row;
        logic [REQ_W-1:0]    kind;
        logic [DELAY_W-1:0]  dly;
        logic [HANDLE_W-1:0] tgt;
        int                  pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, written against the post-reset state:
        // empty queue, ms counter 0, first handle 0.
        plan.push_back(plan_row(REQ_RUN,      24'd0, 16'd0, 1'b1, STAT_NONE, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_CLEAR,    24'd0, 16'hFFFF, 1'b1, STAT_NOTFOUND, 16'hFFFF,
                                1'b0));
        plan.push_back(plan_row(REQ_TICK,     24'd0, 16'd0, 1'b1, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_RESV_LO,  24'hFFFFFF, 16'hFFFF, 1'b1, STAT_OK, 16'd0, 1'b0));
        // zero delay is due at once
        plan.push_back(plan_row(REQ_SET_ONCE, 24'd0, 16'd0, 1'b1, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_RUN,      24'd0, 16'd0, 1'b1, STAT_OK, 16'd0, 1'b0));
        // periodic with zero period acts as one-shot
        plan.push_back(plan_row(REQ_SET_PER,  24'd0, 16'd0, 1'b1, STAT_OK, 16'd1, 1'b0));
        plan.push_back(plan_row(REQ_RUN,      24'd0, 16'd0, 1'b1, STAT_OK, 16'd1, 1'b0));
        // equal deadlines: periodic one first, then the one-shot
        plan.push_back(plan_row(REQ_SET_PER,  24'd2, 16'd0, 1'b1, STAT_OK, 16'd2, 1'b0));
        plan.push_back(plan_row(REQ_SET_ONCE, 24'd2, 16'd0, 1'b1, STAT_OK, 16'd3, 1'b0));
        plan.push_back(plan_row(REQ_RUN,      24'd0, 16'd0, 1'b1, STAT_NONE, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_TICK,     24'd0, 16'd0, 1'b1, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_TICK,     24'd0, 16'd0, 1'b1, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_RUN,      24'd0, 16'd0, 1'b0, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_RUN,      24'd0, 16'd0, 1'b0, STAT_OK, 16'd0, 1'b0));
        // longest delay, then clear hit and clear miss on the same handle
        plan.push_back(plan_row(REQ_SET_ONCE, 24'hFFFFFF, 16'd0, 1'b1, STAT_OK, 16'd4, 1'b0));
        plan.push_back(plan_row(REQ_CLEAR,    24'd0, 16'd4, 1'b1, STAT_OK, 16'd4, 1'b0));
        plan.push_back(plan_row(REQ_CLEAR,    24'd0, 16'd4, 1'b1, STAT_NOTFOUND, 16'd4, 1'b0));
        plan.push_back(plan_row(REQ_CLEAR,    24'd0, 16'd2, 1'b0, STAT_OK, 16'd0, 1'b0));
        // overdue head sorts ahead of one due exactly now
        plan.push_back(plan_row(REQ_SET_ONCE, 24'd1, 16'd0, 1'b0, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_TICK,     24'd0, 16'd0, 1'b0, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_TICK,     24'd0, 16'd0, 1'b0, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_SET_ONCE, 24'd0, 16'd0, 1'b0, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_RUN,      24'd0, 16'd0, 1'b0, STAT_OK, 16'd0, 1'b0));
        plan.push_back(plan_row(REQ_RUN,      24'd0, 16'd0, 1'b0, STAT_OK, 16'd0, 1'b0));

        foreach (plan[i])
        begin
            row = plan[i];
            send_request(row.kind, row.dly, row.tgt, row.fixed, row.status, row.handle,
                         row.periodic);
        end

        // Fill to capacity with full-range delays, then knock on a full queue.
        while (timer_count < CAPACITY)
            send_request($urandom_range(0, 1) ? REQ_SET_PER : REQ_SET_ONCE,
                         DELAY_W'($urandom), HANDLE_W'($urandom), 1'b0, STAT_OK, '0, 1'b0);
        send_request(REQ_SET_ONCE, 24'd5, HANDLE_W'($urandom), 1'b1, STAT_FULL, 16'd0, 1'b0);
        send_request(REQ_SET_PER, 24'hFFFFFF, HANDLE_W'($urandom), 1'b1, STAT_FULL, 16'd0,
                     1'b0);
        send_request(REQ_RUN, DELAY_W'($urandom), HANDLE_W'($urandom), 1'b0, STAT_OK, '0,
                     1'b0);
        while (timer_count > 0)
            send_request(REQ_CLEAR, DELAY_W'($urandom),
                         timers[$urandom_range(0, timer_count - 1)].handle, 1'b0, STAT_OK,
                         '0, 1'b0);

        // Random traffic: mostly short delays so timers come due and
        // periodic ones recycle; some full-range delays and noise.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 20)
                kind = REQ_SET_ONCE;
            else if (pick < 35)
                kind = REQ_SET_PER;
            else if (pick < 47)
                kind = REQ_CLEAR;
            else if (pick < 72)
                kind = REQ_RUN;
            else if (pick < 97)
                kind = REQ_TICK;
            else
                kind = REQ_W'($urandom_range(REQ_RESV_LO, REQ_RESV_HI));

            pick = $urandom_range(0, 9);
            if (kind != REQ_SET_ONCE && kind != REQ_SET_PER)
                dly = DELAY_W'($urandom);
            else if (pick < 7)
                dly = DELAY_W'($urandom_range(0, 8));
            else if (pick < 9)
                dly = DELAY_W'($urandom_range(0, 40));
            else
                dly = DELAY_W'($urandom);

            if (kind == REQ_CLEAR && timer_count > 0 && $urandom_range(0, 4) != 0)
                tgt = timers[$urandom_range(0, timer_count - 1)].handle;
            else
                tgt = HANDLE_W'($urandom);

            send_request(kind, dly, tgt, 1'b0, STAT_OK, '0, 1'b0);
        end

        in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("sorted_deadline_timer_queue test passed");
        else
            $display("sorted_deadline_timer_queue test failed");
        $finish;
    end

endmodule

[files.f]
sv/tdq_pkg.sv
sv/tdq_ctrl.sv
sv/tdq_dp.sv
sv/sorted_deadline_timer_queue.sv
tb/sorted_deadline_timer_queue_tb.sv
